/* rtl/bfa_pkg.sv */
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared constants, codes and the result beat type of the best-fit allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

	localparam int NUM_BLOCKS = 32;
	localparam int NUM_PROCS  = 16;
	localparam int AMT_W      = 16;

	localparam int BLK_AW = $clog2(NUM_BLOCKS);
	localparam int PID_W  = $clog2(NUM_PROCS);
	localparam int WORK_W = AMT_W + $clog2(NUM_BLOCKS + NUM_PROCS);

	localparam int CMD_W    = 2;
	localparam int IDX_W    = 5;
	localparam int STAT_W   = 3;
	localparam int SEQ_W    = 4;
	localparam int PCNT_W   = 5;
	localparam int BCNT_W   = 6;
	localparam int CFG_AW   = 1;
	localparam int CFG_DW   = 6;

	localparam logic [CMD_W-1:0] CMD_LOAD_BLOCK = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_NEED  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REQUEST    = 2'd2;

	localparam logic [STAT_W-1:0] ST_GRANTED  = 3'd0;
	localparam logic [STAT_W-1:0] ST_EXCEEDS  = 3'd1;
	localparam logic [STAT_W-1:0] ST_NO_FIT   = 3'd2;
	localparam logic [STAT_W-1:0] ST_UNSAFE   = 3'd3;
	localparam logic [STAT_W-1:0] ST_LOADED   = 3'd4;
	localparam logic [STAT_W-1:0] ST_BAD_IDX  = 3'd5;

	localparam logic [CFG_AW-1:0] REG_PROC_COUNT  = 1'd0;
	localparam logic [CFG_AW-1:0] REG_BLOCK_COUNT = 1'd1;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [SEQ_W-1:0]  seq_pid;
		logic [AMT_W-1:0]  block_left;
		logic              last;
	} rsp_beat_t;

endpackage

/* rtl/bfa_req_if.sv */
// ----------------------------------------------------------------------------
// bfa_req_if
// Input item channel: command, index and amount with valid/ready.
// ----------------------------------------------------------------------------
interface bfa_req_if;
	logic                        valid;
	logic                        ready;
	logic [bfa_pkg::CMD_W-1:0]   cmd;
	logic [bfa_pkg::IDX_W-1:0]   index;
	logic [bfa_pkg::AMT_W-1:0]   amount;

	modport source (output valid, cmd, index, amount, input ready);
	modport sink   (input valid, cmd, index, amount, output ready);
endinterface

/* rtl/bfa_rsp_if.sv */
// ----------------------------------------------------------------------------
// bfa_rsp_if
// Result channel: status, safe sequence entry, block remainder, last flag.
// ----------------------------------------------------------------------------
interface bfa_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [bfa_pkg::STAT_W-1:0]   status;
	logic [bfa_pkg::SEQ_W-1:0]    seq_pid;
	logic [bfa_pkg::AMT_W-1:0]    block_left;
	logic                         last;

	modport source (output valid, status, seq_pid, block_left, last, input ready);
	modport sink   (input valid, status, seq_pid, block_left, last, output ready);
endinterface

/* rtl/bfa_cfg_if.sv */
// ----------------------------------------------------------------------------
// bfa_cfg_if
// Register write channel: register index and write data with valid/ready.
// ----------------------------------------------------------------------------
interface bfa_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [bfa_pkg::CFG_AW-1:0]   index;
	logic [bfa_pkg::CFG_DW-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/best_fit_alloc_with_safety_check_unit.sv */
// ----------------------------------------------------------------------------
// best_fit_alloc_with_safety_check_unit
// Best-fit block allocator guarded by a single-resource banker's check.
// Flow: a load or bad-index item goes from decode straight to its result beat;
// a request refused on need goes through the need check first. A request that
// passes bubble-sorts the blocks in block RAM, scans them for the best fit, runs
// banker's safety passes over the processes (up to np passes), then emits np
// result beats. One item at a time.
// Reset clears control and allocations and sets counts (16 processes, 32 blocks).
// ----------------------------------------------------------------------------
module best_fit_alloc_with_safety_check_unit (
	input  logic       clk,
	input  logic       arst_n,
	bfa_cfg_if.sink    cfg,
	bfa_req_if.sink    req,
	bfa_rsp_if.source  rsp
);

	localparam int PCW = bfa_pkg::PCNT_W;
	localparam int BCW = bfa_pkg::BCNT_W;

	// configuration registers, clamped copies feed the sequencer
	logic [PCW-1:0] proc_count_q;
	logic [BCW-1:0] block_count_q;
	logic [PCW-1:0] np;
	logic [BCW-1:0] nb;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proc_count_q  <= PCW'(bfa_pkg::NUM_PROCS);
			block_count_q <= BCW'(bfa_pkg::NUM_BLOCKS);
		end else if (cfg.valid) begin
			case (cfg.index)
				bfa_pkg::REG_PROC_COUNT:  proc_count_q  <= cfg.data[PCW-1:0];
				bfa_pkg::REG_BLOCK_COUNT: block_count_q <= cfg.data[BCW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		np = proc_count_q;
		if (proc_count_q == '0) np = PCW'(1);
		else if (proc_count_q > PCW'(bfa_pkg::NUM_PROCS)) np = PCW'(bfa_pkg::NUM_PROCS);
		nb = block_count_q;
		if (block_count_q == '0) nb = BCW'(1);
		else if (block_count_q > BCW'(bfa_pkg::NUM_BLOCKS)) nb = BCW'(bfa_pkg::NUM_BLOCKS);
	end

	// output register: holds one beat, refilled as it drains
	logic               out_v_q;
	bfa_pkg::rsp_beat_t out_q;
	bfa_pkg::rsp_beat_t beat;
	logic               push, slot_free;

	assign slot_free = !out_v_q || rsp.ready;

	bfa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .np(np), .nb(nb),
		.req_valid(req.valid), .req_ready(req.ready),
		.req_cmd(req.cmd), .req_index(req.index), .req_amount(req.amount),
		.slot_free(slot_free), .push(push), .beat(beat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (slot_free) begin
			out_v_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push) out_q <= beat;
	end

	assign rsp.valid      = out_v_q;
	assign rsp.status     = out_q.status;
	assign rsp.seq_pid    = out_q.seq_pid;
	assign rsp.block_left = out_q.block_left;
	assign rsp.last       = out_q.last;

	// one item in flight: no new input accepted right after one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("input accepted while an item is in flight");

	// refusals and loads are single-beat items with empty payload
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != bfa_pkg::ST_GRANTED |->
		rsp.last && rsp.seq_pid == '0 && rsp.block_left == '0)
		else $error("non-grant beat is not a lone empty beat");

	// no result beat is produced while an input is being accepted
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !req.ready)
		else $error("result pushed while idle");

endmodule

/* rtl/bfa_ram.sv */
// ----------------------------------------------------------------------------
// bfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfa_ram #(
	parameter int W = 16,
	parameter int D = 32
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/bfa_ctrl.sv */
// ----------------------------------------------------------------------------
// bfa_ctrl
// Sequencer: loads, need check, in-memory bubble sort, best-fit scan,
// banker's safety passes, rollback and result emission.
// ----------------------------------------------------------------------------
module bfa_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [bfa_pkg::PCNT_W-1:0]    np,
	input  logic [bfa_pkg::BCNT_W-1:0]    nb,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic [bfa_pkg::CMD_W-1:0]     req_cmd,
	input  logic [bfa_pkg::IDX_W-1:0]     req_index,
	input  logic [bfa_pkg::AMT_W-1:0]     req_amount,
	input  logic                          slot_free,
	output logic                          push,
	output bfa_pkg::rsp_beat_t            beat
);

	localparam int AW  = bfa_pkg::AMT_W;
	localparam int BAW = bfa_pkg::BLK_AW;
	localparam int PW  = bfa_pkg::PID_W;
	localparam int WW  = bfa_pkg::WORK_W;
	localparam int CW  = bfa_pkg::PCNT_W;

	localparam logic [bfa_pkg::BCNT_W-1:0] BCNT1 = 1;

	localparam logic [3:0] S_IDLE       = 4'd0;
	localparam logic [3:0] S_DEC        = 4'd1;
	localparam logic [3:0] S_CHK        = 4'd2;
	localparam logic [3:0] S_SORT_FIRST = 4'd3;
	localparam logic [3:0] S_SORT_RUN   = 4'd4;
	localparam logic [3:0] S_SORT_TAIL  = 4'd5;
	localparam logic [3:0] S_SCAN       = 4'd6;
	localparam logic [3:0] S_APPLY      = 4'd7;
	localparam logic [3:0] S_SAFE_LD    = 4'd8;
	localparam logic [3:0] S_SAFE_RUN   = 4'd9;
	localparam logic [3:0] S_ROLLBACK   = 4'd10;
	localparam logic [3:0] S_EMIT       = 4'd11;
	localparam logic [3:0] S_RESP       = 4'd12;

	logic [3:0] state_q;

	logic [bfa_pkg::CMD_W-1:0]  cmd_q;
	logic [bfa_pkg::IDX_W-1:0]  idx_q;
	logic [AW-1:0]              amt_q;
	logic [bfa_pkg::STAT_W-1:0] stat_q;

	logic [AW-1:0]  max_q, alloc_q, cur_q, pickval_q, left_q;
	logic [BAW-1:0] j_q, end_q, pick_q;
	logic [WW-1:0]  sum_q, work_q;
	logic           found_q;
	logic [PW-1:0]  p_q, paddr_s1;
	logic [CW-1:0]  cnt_q;
	logic [bfa_pkg::NUM_PROCS-1:0] done_q, alloc_v_q;
	logic [PW-1:0]  seq_q [bfa_pkg::NUM_PROCS];
	logic [PW-1:0]  k_q;

	// memory ports
	logic           blk_we;
	logic [BAW-1:0] blk_waddr, blk_raddr;
	logic [AW-1:0]  blk_wdata, blk_rdata;
	logic           prc_we;
	logic [PW-1:0]  prc_waddr, prc_raddr;
	logic [2*AW-1:0] prc_wdata, prc_rdata;

	bfa_ram #(.W(AW), .D(bfa_pkg::NUM_BLOCKS)) u_blk_ram (
		.clk(clk), .we(blk_we), .waddr(blk_waddr), .wdata(blk_wdata),
		.raddr(blk_raddr), .rdata(blk_rdata)
	);

	bfa_ram #(.W(2*AW), .D(bfa_pkg::NUM_PROCS)) u_prc_ram (
		.clk(clk), .we(prc_we), .waddr(prc_waddr), .wdata(prc_wdata),
		.raddr(prc_raddr), .rdata(prc_rdata)
	);

	// decoded read data
	logic [AW-1:0] r_max, r_alloc, r_need, rem, sort_lo, sort_hi;
	logic          fit, take, pass_end, idx_blk_bad, idx_prc_bad;
	logic [CW-1:0] cnt_n;
	logic          found_scan_n, found_safe_n;
	logic [PW-1:0] pid;

	always_comb begin
		pid         = idx_q[PW-1:0];
		idx_blk_bad = {1'b0, idx_q} >= nb;
		idx_prc_bad = idx_q >= np;
		r_max       = prc_rdata[2*AW-1:AW];
		r_alloc     = alloc_v_q[paddr_s1] ? prc_rdata[AW-1:0] : '0;
		r_need      = (r_max >= r_alloc) ? r_max - r_alloc : '0;
		rem         = r_need;
		sort_lo     = (cur_q > blk_rdata) ? blk_rdata : cur_q;
		sort_hi     = (cur_q > blk_rdata) ? cur_q : blk_rdata;
		fit         = !found_q && (blk_rdata >= amt_q);
		found_scan_n = found_q | fit;
		take        = !done_q[p_q] && (work_q >= WW'(r_need));
		cnt_n       = cnt_q + CW'(take);
		found_safe_n = found_q | take;
		pass_end    = {1'b0, p_q} == (np - CW'(1));
	end

	// memory control
	always_comb begin
		blk_we    = 1'b0;
		blk_waddr = '0;
		blk_wdata = '0;
		blk_raddr = '0;
		prc_we    = 1'b0;
		prc_waddr = pid;
		prc_wdata = '0;
		prc_raddr = pid;
		case (state_q)
			S_DEC: begin
				if (cmd_q == bfa_pkg::CMD_LOAD_BLOCK && !idx_blk_bad) begin
					blk_we    = 1'b1;
					blk_waddr = idx_q[BAW-1:0];
					blk_wdata = amt_q;
				end
				if (cmd_q == bfa_pkg::CMD_LOAD_NEED && !idx_prc_bad) begin
					prc_we    = 1'b1;
					prc_wdata = {amt_q, {AW{1'b0}}};
				end
			end
			S_SORT_FIRST: blk_raddr = BAW'(1);
			S_SORT_RUN: begin
				blk_we    = 1'b1;
				blk_waddr = j_q - BAW'(1);
				blk_wdata = sort_lo;
				blk_raddr = j_q + BAW'(1);
			end
			S_SORT_TAIL: begin
				blk_we    = 1'b1;
				blk_waddr = end_q;
				blk_wdata = cur_q;
			end
			S_SCAN: blk_raddr = j_q + BAW'(1);
			S_APPLY: begin
				blk_we    = 1'b1;
				blk_waddr = pick_q;
				blk_wdata = pickval_q - amt_q;
				prc_we    = 1'b1;
				prc_wdata = {max_q, alloc_q + amt_q};
			end
			S_SAFE_LD: prc_raddr = '0;
			S_SAFE_RUN: prc_raddr = pass_end ? '0 : p_q + PW'(1);
			S_ROLLBACK: begin
				blk_we    = 1'b1;
				blk_waddr = pick_q;
				blk_wdata = pickval_q;
				prc_we    = 1'b1;
				prc_wdata = {max_q, alloc_q};
			end
			default: ;
		endcase
	end

	// result beats
	always_comb begin
		push            = 1'b0;
		beat.status     = stat_q;
		beat.seq_pid    = '0;
		beat.block_left = '0;
		beat.last       = 1'b1;
		if (state_q == S_RESP) begin
			push = slot_free;
		end else if (state_q == S_EMIT) begin
			push            = slot_free;
			beat.status     = bfa_pkg::ST_GRANTED;
			beat.seq_pid    = bfa_pkg::SEQ_W'(seq_q[k_q]);
			beat.block_left = left_q;
			beat.last       = {1'b0, k_q} == (np - CW'(1));
		end
	end

	assign req_ready = (state_q == S_IDLE);

	always_ff @(posedge clk) begin
		paddr_s1 <= prc_raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			alloc_v_q <= '0;
			done_q    <= '0;
			found_q   <= 1'b0;
			cnt_q     <= '0;
			k_q       <= '0;
		end else begin
			if (prc_we) begin
				alloc_v_q[prc_waddr] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						cmd_q   <= req_cmd;
						idx_q   <= req_index;
						amt_q   <= req_amount;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					case (cmd_q)
						bfa_pkg::CMD_LOAD_BLOCK: begin
							state_q <= S_RESP;
							stat_q  <= idx_blk_bad ? bfa_pkg::ST_BAD_IDX
							                       : bfa_pkg::ST_LOADED;
						end
						bfa_pkg::CMD_LOAD_NEED: begin
							state_q <= S_RESP;
							stat_q  <= idx_prc_bad ? bfa_pkg::ST_BAD_IDX
							                       : bfa_pkg::ST_LOADED;
						end
						bfa_pkg::CMD_REQUEST: begin
							if (idx_prc_bad) begin
								stat_q  <= bfa_pkg::ST_BAD_IDX;
								state_q <= S_RESP;
							end else begin
								state_q <= S_CHK;
							end
						end
						default: begin
							stat_q  <= bfa_pkg::ST_BAD_IDX;
							state_q <= S_RESP;
						end
					endcase
				end
				S_CHK: begin
					max_q   <= r_max;
					alloc_q <= r_alloc;
					j_q     <= '0;
					sum_q   <= '0;
					found_q <= 1'b0;
					end_q   <= BAW'(nb - BCNT1);
					if (amt_q > rem) begin
						stat_q  <= bfa_pkg::ST_EXCEEDS;
						state_q <= S_RESP;
					end else if (nb == BCNT1) begin
						state_q <= S_SCAN;
					end else begin
						state_q <= S_SORT_FIRST;
					end
				end
				S_SORT_FIRST: begin
					cur_q   <= blk_rdata;
					j_q     <= BAW'(1);
					state_q <= S_SORT_RUN;
				end
				S_SORT_RUN: begin
					cur_q <= sort_hi;
					if (j_q == end_q) begin
						state_q <= S_SORT_TAIL;
					end else begin
						j_q <= j_q + BAW'(1);
					end
				end
				S_SORT_TAIL: begin
					j_q <= '0;
					if (end_q == BAW'(1)) begin
						state_q <= S_SCAN;
					end else begin
						end_q   <= end_q - BAW'(1);
						state_q <= S_SORT_FIRST;
					end
				end
				S_SCAN: begin
					sum_q   <= sum_q + WW'(blk_rdata);
					found_q <= found_scan_n;
					if (fit) begin
						pick_q    <= j_q;
						pickval_q <= blk_rdata;
					end
					j_q <= j_q + BAW'(1);
					if ({1'b0, j_q} == nb - BCNT1) begin
						if (found_scan_n) begin
							state_q <= S_APPLY;
						end else begin
							stat_q  <= bfa_pkg::ST_NO_FIT;
							state_q <= S_RESP;
						end
					end
				end
				S_APPLY: begin
					work_q  <= sum_q - WW'(amt_q);
					done_q  <= '0;
					cnt_q   <= '0;
					found_q <= 1'b0;
					left_q  <= pickval_q - amt_q;
					state_q <= S_SAFE_LD;
				end
				S_SAFE_LD: begin
					p_q     <= '0;
					state_q <= S_SAFE_RUN;
				end
				S_SAFE_RUN: begin
					if (take) begin
						work_q           <= work_q + WW'(r_alloc);
						done_q[p_q]      <= 1'b1;
						seq_q[cnt_q[PW-1:0]] <= p_q;
					end
					cnt_q <= cnt_n;
					if (pass_end) begin
						p_q     <= '0;
						found_q <= 1'b0;
						if (cnt_n == np) begin
							k_q     <= '0;
							state_q <= S_EMIT;
						end else if (!found_safe_n) begin
							state_q <= S_ROLLBACK;
						end
					end else begin
						p_q     <= p_q + PW'(1);
						found_q <= found_safe_n;
					end
				end
				S_ROLLBACK: begin
					stat_q  <= bfa_pkg::ST_UNSAFE;
					state_q <= S_RESP;
				end
				S_EMIT: begin
					if (slot_free) begin
						k_q <= k_q + PW'(1);
						if (beat.last) state_q <= S_IDLE;
					end
				end
				S_RESP: begin
					if (slot_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
